@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int PRIO_W    = 16;
  localparam int PAY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_INSPECT = 2'd2
  } spq_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOOP,
    S_STEP,
    S_FINISH
  } spq_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PRIO_W-1:0] priority_req;
    logic [PAY_W-1:0]  payload;
  } spq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [PAY_W-1:0]     removed_payload;
    logic [PRIO_W-1:0]    removed_priority;
    logic                 head_valid;
    logic [PRIO_W-1:0]    head_priority;
    logic [PAY_W-1:0]     head_payload;
    logic [CNT_OUT_W-1:0] entry_count;
  } spq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic check;    // decide status and removed entry
    logic rd;       // read the slot at the walk index
    logic step;     // process the read slot, advance the index
    logic wrap;     // final write / count update at the end of the walk
    logic capture;  // load the output register
  } spq_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_walk;  // item needs no pass over the slots
    logic at_end;   // walk index reached the entry count
    logic out_busy; // output register holds a result not yet taken
  } spq_sts_t;

endpackage

@@ src/sorted_priority_queue_unit.sv @@
// Commands are handled one at a time: a new one is taken only after the
// previous one is done. An enqueue or dequeue walks the slot memory with one
// read and one write per slot; inspect and refused operations need no walk.
// Reset (rst_n, synchronous, active low) empties the queue, selects ascending
// order and drops any pending result; slot contents are left as they were.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  // Order register: 0 keeps the least priority at the head, 1 the greatest.
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  // Command channel.
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  // Result channel.
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  // The entries live in a sorted slot memory with the head in slot 0. Each
  // command is handled by a controller that walks the datapath over the held
  // slots: an enqueue reads every slot from the head, drops the new entry in
  // before the first one it strictly outranks (so equal priorities keep their
  // arrival order), and ripples the rest up by one; a dequeue shifts every
  // entry down by one. The head is kept in a register so that each result can
  // report it without an extra memory read.
  //
  // The result sits in an output register, so a new command transfer can be
  // taken while the previous result still waits on out_ready.

  spq_ctl_t ctl;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

@@ src/spq_ctrl.sv @@
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output spq_ctl_t ctl,
  input  spq_sts_t sts
);

  spq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        ctl.check = 1'b1;
        state_nxt = sts.no_walk ? S_FINISH : S_LOOP;
      end
      S_LOOP: begin
        if (sts.at_end) begin
          ctl.wrap  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          ctl.rd    = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        ctl.step  = 1'b1;
        state_nxt = S_LOOP;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          ctl.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/spq_datapath.sv @@
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  spq_in_t  in_data,
  input  logic     out_ready,
  output logic     out_valid,
  output spq_out_t out_data,
  input  spq_ctl_t ctl,
  output spq_sts_t sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [PRIO_W-1:0] mem_prio [CAPACITY];
  logic [PAY_W-1:0]  mem_pay  [CAPACITY];

  logic              desc_r;
  spq_in_t           item_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic              placed_r;
  logic [PRIO_W-1:0] carry_prio_r;
  logic [PAY_W-1:0]  carry_pay_r;
  logic [PRIO_W-1:0] head_prio_r;
  logic [PAY_W-1:0]  head_pay_r;
  logic [PRIO_W-1:0] rem_prio_r;
  logic [PAY_W-1:0]  rem_pay_r;
  spq_status_t       stat_r;
  logic [PRIO_W-1:0] rd_prio_r;
  logic [PAY_W-1:0]  rd_pay_r;
  logic              out_valid_r;
  spq_out_t          out_r;

  logic              is_enq, is_deq, full, empty, outranks;
  logic [CW-1:0]     idx_m1;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [PRIO_W-1:0] wr_prio;
  logic [PAY_W-1:0]  wr_pay;

  assign is_enq   = (item_r.cmd == OP_ENQ);
  assign is_deq   = (item_r.cmd == OP_DEQ);
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign idx_m1   = idx_r - 1'b1;
  assign outranks = desc_r ? (item_r.priority_req > rd_prio_r)
                           : (item_r.priority_req < rd_prio_r);

  assign sts.no_walk  = !(is_enq && !full) && !(is_deq && !empty);
  assign sts.at_end   = (idx_r == count_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  // Single write port. An enqueue either leaves a slot alone until the new
  // entry is placed, then ripples the displaced entries up by one; a dequeue
  // moves every entry down by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_prio = item_r.priority_req;
    wr_pay  = item_r.payload;
    if (ctl.step) begin
      if (is_enq) begin
        if (placed_r) begin
          wr_en   = 1'b1;
          wr_prio = carry_prio_r;
          wr_pay  = carry_pay_r;
        end else if (outranks) begin
          wr_en = 1'b1;
        end
      end else begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        wr_prio = rd_prio_r;
        wr_pay  = rd_pay_r;
      end
    end else if (ctl.wrap && is_enq) begin
      wr_en = 1'b1;
      if (placed_r) begin
        wr_prio = carry_prio_r;
        wr_pay  = carry_pay_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prio[wr_addr] <= wr_prio;
      mem_pay[wr_addr]  <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_prio_r <= mem_prio[idx_r[AW-1:0]];
      rd_pay_r  <= mem_pay[idx_r[AW-1:0]];
    end
  end

  // Payload-side registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.step && (placed_r || outranks)) begin
      carry_prio_r <= rd_prio_r;
      carry_pay_r  <= rd_pay_r;
    end
    // Whatever lands in slot 0 is the new head.
    if (wr_en && (wr_addr == '0)) begin
      head_prio_r <= wr_prio;
      head_pay_r  <= wr_pay;
    end
    if (ctl.check) begin
      if (is_deq && !empty) begin
        rem_prio_r <= head_prio_r;
        rem_pay_r  <= head_pay_r;
      end else begin
        rem_prio_r <= '0;
        rem_pay_r  <= '0;
      end
      if (is_enq && full) begin
        stat_r <= ST_FULL;
      end else if (is_deq && empty) begin
        stat_r <= ST_EMPTY;
      end else begin
        stat_r <= ST_DONE;
      end
    end
    if (ctl.capture) begin
      out_r.status           <= stat_r;
      out_r.removed_payload  <= rem_pay_r;
      out_r.removed_priority <= rem_prio_r;
      out_r.head_valid       <= !empty;
      out_r.head_priority    <= empty ? '0 : head_prio_r;
      out_r.head_payload     <= empty ? '0 : head_pay_r;
      out_r.entry_count      <= CNT_OUT_W'(count_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      if (ctl.load) begin
        idx_r    <= (in_data.cmd == OP_DEQ) ? CW'(1) : '0;
        placed_r <= 1'b0;
      end else if (ctl.step) begin
        idx_r <= idx_r + 1'b1;
        if (is_enq && outranks) begin
          placed_r <= 1'b1;
        end
      end
      if (ctl.wrap) begin
        count_r <= is_enq ? count_r + 1'b1 : count_r - 1'b1;
      end
      if (ctl.capture) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
